/* src/pdee_pkg.sv */
// Package for the postfix expression evaluator: item types, character codes,
// stack sizing, controller state and the controller/datapath command structs.
// Depends on nothing.
`timescale 1ns / 1ps

package pdee_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int PTR_W       = $clog2(STACK_DEPTH);
  localparam int VAL_W       = 32;
  localparam int DIV_CNT_W   = $clog2(VAL_W);

  localparam logic [7:0] CODE_ZERO  = 8'd48;
  localparam logic [7:0] CODE_PLUS  = 8'd43;
  localparam logic [7:0] CODE_MINUS = 8'd45;
  localparam logic [7:0] CODE_STAR  = 8'd42;
  localparam logic [7:0] CODE_SLASH = 8'd47;

  localparam logic [VAL_W-1:0] EMPTY_POP_VALUE = '1;

  typedef struct packed {
    logic [7:0] symbol;
    logic       end_of_expression;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    last;
    logic                    no_value;
    logic                    overflow_seen;
    logic                    underflow_seen;
    logic                    div_zero_seen;
  } out_item_t;

  typedef struct packed {
    logic ovf;
    logic unf;
    logic dz;
  } err_flags_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_POP_RHS,
    S_CAP_RHS,
    S_POP_LHS,
    S_CAP_LHS,
    S_EXEC,
    S_DIV,
    S_PUSH,
    S_DRAIN,
    S_DRAIN_RD,
    S_DRAIN_CAP
  } ctrl_state_t;

  typedef struct packed {
    logic latch_in;
    logic pop_rhs;
    logic cap_rhs;
    logic pop_lhs;
    logic cap_lhs;
    logic alu;
    logic div_zero;
    logic div_start;
    logic div_take;
    logic push;
    logic drain_rd;
    logic load_empty;
    logic load_entry;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_op;
    logic is_div;
    logic eoe;
    logic count_zero;
    logic rhs_zero;
    logic out_free;
    logic div_done;
  } dp_status_t;

endpackage

/* src/pdee_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module pdee_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* src/pdee_div.sv */
// Iterative unsigned restoring divider, one quotient bit per cycle.
// Depends on pdee_pkg for the value width.
`timescale 1ns / 1ps

module pdee_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [pdee_pkg::VAL_W-1:0]   dividend,
  input  logic [pdee_pkg::VAL_W-1:0]   divisor,
  output logic                         done,
  output logic [pdee_pkg::VAL_W-1:0]   quotient
);

  localparam int W = pdee_pkg::VAL_W;

  logic [W-1:0]                        rem_r, rem_nxt;
  logic [W-1:0]                        quo_r, quo_nxt;
  logic [W-1:0]                        dsr_r, dsr_nxt;
  logic [pdee_pkg::DIV_CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                                busy_r, busy_nxt;
  logic                                done_r, done_nxt;
  logic [W:0]                          rem_sh;
  logic [W:0]                          trial;

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_sh   = {rem_r, quo_r[W-1]};
    trial    = rem_sh - {1'b0, dsr_r};
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dsr_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // Shift in one dividend bit, keep the trial difference when it fits.
      if (!trial[W]) begin
        rem_nxt = trial[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == pdee_pkg::DIV_CNT_W'(W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

/* src/pdee_dp.sv */
// Datapath: input latch, stack pointer and RAM, operand registers, ALU,
// divider, error flags and the output register.
// Depends on pdee_pkg, pdee_ram and pdee_div.
`timescale 1ns / 1ps

module pdee_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pdee_pkg::in_item_t    in_data,
  input  pdee_pkg::ctrl_cmd_t   cmd,
  output pdee_pkg::dp_status_t  status,
  output logic                  out_valid,
  input  logic                  out_ready,
  output pdee_pkg::out_item_t   out_data
);

  localparam int W = pdee_pkg::VAL_W;

  logic [7:0]                  sym_r, sym_nxt;
  logic                        eoe_r, eoe_nxt;
  logic [pdee_pkg::CNT_W-1:0]  count_r, count_nxt;
  pdee_pkg::err_flags_t        flags_r, flags_nxt;
  logic [W-1:0]                rhs_r, rhs_nxt;
  logic [W-1:0]                lhs_r, lhs_nxt;
  logic [W-1:0]                res_r, res_nxt;
  logic                        neg_r, neg_nxt;
  pdee_pkg::out_item_t         out_r, out_nxt;
  logic                        out_valid_r, out_valid_nxt;

  logic                        ram_we, ram_re;
  logic [pdee_pkg::PTR_W-1:0]  ram_waddr, ram_raddr;
  logic [W-1:0]                ram_wdata, ram_rdata;
  logic [W-1:0]                ua, ub, quotient;
  logic                        div_done;
  logic                        is_op, count_zero, out_free;

  assign is_op = (sym_r == pdee_pkg::CODE_PLUS) || (sym_r == pdee_pkg::CODE_MINUS) ||
                 (sym_r == pdee_pkg::CODE_STAR) || (sym_r == pdee_pkg::CODE_SLASH);
  assign count_zero = (count_r == '0);
  assign out_free   = !out_valid_r || out_ready;

  assign ua = lhs_r[W-1] ? (W'(0) - lhs_r) : lhs_r;
  assign ub = rhs_r[W-1] ? (W'(0) - rhs_r) : rhs_r;

  pdee_ram #(
    .WIDTH (W),
    .DEPTH (pdee_pkg::STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pdee_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (ua),
    .divisor  (ub),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    sym_nxt       = sym_r;
    eoe_nxt       = eoe_r;
    count_nxt     = count_r;
    flags_nxt     = flags_r;
    rhs_nxt       = rhs_r;
    lhs_nxt       = lhs_r;
    res_nxt       = res_r;
    neg_nxt       = neg_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    ram_we        = 1'b0;
    ram_waddr     = pdee_pkg::PTR_W'(count_r);
    ram_wdata     = res_r;
    ram_re        = 1'b0;
    ram_raddr     = pdee_pkg::PTR_W'(count_r - 1'b1);

    if (cmd.latch_in) begin
      sym_nxt = in_data.symbol;
      eoe_nxt = in_data.end_of_expression;
    end

    // Pop: an empty stack yields all ones and marks underflow.
    if (cmd.pop_rhs || cmd.pop_lhs) begin
      if (count_zero) begin
        flags_nxt.unf = 1'b1;
        if (cmd.pop_rhs) begin
          rhs_nxt = pdee_pkg::EMPTY_POP_VALUE;
        end else begin
          lhs_nxt = pdee_pkg::EMPTY_POP_VALUE;
        end
      end else begin
        ram_re    = 1'b1;
        count_nxt = count_r - 1'b1;
      end
    end
    if (cmd.cap_rhs) begin
      rhs_nxt = ram_rdata;
    end
    if (cmd.cap_lhs) begin
      lhs_nxt = ram_rdata;
    end

    if (cmd.alu) begin
      case (sym_r)
        pdee_pkg::CODE_PLUS:  res_nxt = lhs_r + rhs_r;
        pdee_pkg::CODE_MINUS: res_nxt = lhs_r - rhs_r;
        default:              res_nxt = lhs_r * rhs_r;
      endcase
    end
    if (cmd.div_zero) begin
      res_nxt      = '0;
      flags_nxt.dz = 1'b1;
    end
    if (cmd.div_start) begin
      neg_nxt = lhs_r[W-1] ^ rhs_r[W-1];
    end
    if (cmd.div_take) begin
      res_nxt = neg_r ? (W'(0) - quotient) : quotient;
    end

    // Push: operators push the result, anything else its code minus '0'; a full stack drops it and marks overflow.
    if (cmd.push) begin
      ram_wdata = is_op ? res_r : (W'(sym_r) - W'(pdee_pkg::CODE_ZERO));
      if (count_r >= pdee_pkg::CNT_W'(pdee_pkg::STACK_DEPTH)) begin
        flags_nxt.ovf = 1'b1;
      end else begin
        ram_we    = 1'b1;
        count_nxt = count_r + 1'b1;
      end
    end

    if (cmd.drain_rd) begin
      ram_re    = 1'b1;
      count_nxt = count_r - 1'b1;
    end

    if (cmd.load_empty || cmd.load_entry) begin
      out_nxt.value          = cmd.load_entry ? $signed(ram_rdata) : '0;
      out_nxt.last           = cmd.load_empty || count_zero;
      out_nxt.no_value       = cmd.load_empty;
      out_nxt.overflow_seen  = flags_r.ovf;
      out_nxt.underflow_seen = flags_r.unf;
      out_nxt.div_zero_seen  = flags_r.dz;
      out_valid_nxt          = 1'b1;
      // Clear the sticky flags once the final result of the drain is taken in.
      if (cmd.load_empty || count_zero) begin
        flags_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      flags_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      flags_r     <= flags_nxt;
      out_valid_r <= out_valid_nxt;
    end
    sym_r <= sym_nxt;
    eoe_r <= eoe_nxt;
    rhs_r <= rhs_nxt;
    lhs_r <= lhs_nxt;
    res_r <= res_nxt;
    neg_r <= neg_nxt;
    out_r <= out_nxt;
  end

  assign status.is_op      = is_op;
  assign status.is_div     = (sym_r == pdee_pkg::CODE_SLASH);
  assign status.eoe        = eoe_r;
  assign status.count_zero = count_zero;
  assign status.rhs_zero   = (rhs_r == '0);
  assign status.out_free   = out_free;
  assign status.div_done   = div_done;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* src/pdee_ctrl.sv */
// Controller state machine: sequences pops, execution, push and drain.
// Depends on pdee_pkg.
`timescale 1ns / 1ps

module pdee_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  pdee_pkg::dp_status_t  status,
  output pdee_pkg::ctrl_cmd_t   cmd
);

  pdee_pkg::ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pdee_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      pdee_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = pdee_pkg::S_DECODE;
        end
      end
      pdee_pkg::S_DECODE: begin
        state_nxt = status.is_op ? pdee_pkg::S_POP_RHS : pdee_pkg::S_PUSH;
      end
      pdee_pkg::S_POP_RHS: begin
        cmd.pop_rhs = 1'b1;
        state_nxt   = status.count_zero ? pdee_pkg::S_POP_LHS : pdee_pkg::S_CAP_RHS;
      end
      pdee_pkg::S_CAP_RHS: begin
        cmd.cap_rhs = 1'b1;
        state_nxt   = pdee_pkg::S_POP_LHS;
      end
      pdee_pkg::S_POP_LHS: begin
        cmd.pop_lhs = 1'b1;
        state_nxt   = status.count_zero ? pdee_pkg::S_EXEC : pdee_pkg::S_CAP_LHS;
      end
      pdee_pkg::S_CAP_LHS: begin
        cmd.cap_lhs = 1'b1;
        state_nxt   = pdee_pkg::S_EXEC;
      end
      pdee_pkg::S_EXEC: begin
        if (!status.is_div) begin
          cmd.alu   = 1'b1;
          state_nxt = pdee_pkg::S_PUSH;
        end else if (status.rhs_zero) begin
          cmd.div_zero = 1'b1;
          state_nxt    = pdee_pkg::S_PUSH;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = pdee_pkg::S_DIV;
        end
      end
      pdee_pkg::S_DIV: begin
        if (status.div_done) begin
          cmd.div_take = 1'b1;
          state_nxt    = pdee_pkg::S_PUSH;
        end
      end
      pdee_pkg::S_PUSH: begin
        cmd.push  = 1'b1;
        state_nxt = status.eoe ? pdee_pkg::S_DRAIN : pdee_pkg::S_IDLE;
      end
      pdee_pkg::S_DRAIN: begin
        if (!status.count_zero) begin
          state_nxt = pdee_pkg::S_DRAIN_RD;
        end else if (status.out_free) begin
          cmd.load_empty = 1'b1;
          state_nxt      = pdee_pkg::S_IDLE;
        end
      end
      pdee_pkg::S_DRAIN_RD: begin
        cmd.drain_rd = 1'b1;
        state_nxt    = pdee_pkg::S_DRAIN_CAP;
      end
      pdee_pkg::S_DRAIN_CAP: begin
        // Hold the read data until the output register is free.
        if (status.out_free) begin
          cmd.load_entry = 1'b1;
          state_nxt      = status.count_zero ? pdee_pkg::S_IDLE : pdee_pkg::S_DRAIN_RD;
        end
      end
      default: begin
        state_nxt = pdee_pkg::S_IDLE;
      end
    endcase
  end

endmodule

/* src/postfix_digit_expression_evaluator_top.sv */
// Top level of the postfix expression evaluator: controller plus datapath.
// Depends on pdee_pkg, pdee_ctrl and pdee_dp (with pdee_ram and pdee_div).
//
//   Channel  Direction  Handshake              Payload
//   in_      input      in_valid / in_ready    pdee_pkg::in_item_t (symbol, end marker)
//   out_     output     out_valid / out_ready  pdee_pkg::out_item_t (value, last, flags)
//
// Sequence: an operand character passes through decode and push; +, - and *
// also pop two operands through the registered read port of the stack RAM (a
// pop of an empty stack skips its capture state); a division by a non-zero
// value further waits on the one-bit-per-cycle divider.
// The end marker adds a drain state, then a RAM read and an output load per
// drained entry, or a direct empty-result load for an empty stack.
// Reset: rst_n synchronous, active low; clears the stack count, flags, state
// and output valid. The stack RAM needs no clearing pass.
// Stalls: the output register holds a result while out_ready is low; the drain
// waits on it, and the next transfer in is accepted once the drain has loaded
// its final result, while that result may still wait at the output.
`timescale 1ns / 1ps

module postfix_digit_expression_evaluator_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pdee_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output pdee_pkg::out_item_t  out_data
);

  // Commands run from controller to datapath, status runs back.
  pdee_pkg::ctrl_cmd_t  cmd;
  pdee_pkg::dp_status_t status;

  pdee_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  pdee_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* src/pdee_checker.sv */
// Port-level checks on the postfix expression evaluator, bound to its top.
// Depends on pdee_pkg and postfix_digit_expression_evaluator_top.
`timescale 1ns / 1ps

module pdee_port_assertions (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input pdee_pkg::in_item_t   in_data,
  input logic                 out_valid,
  input logic                 out_ready,
  input pdee_pkg::out_item_t  out_data
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output changed while stalled");

  // An empty-stack result carries a zero value and ends the drain.
  a_no_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.no_value |-> out_data.last && (out_data.value == '0))
    else $error("no-value result malformed");

  // One item at a time: ready drops after each input transfer.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted twice in a row");

  // A waiting input item holds until its transfer.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input changed while waiting");

endmodule

bind postfix_digit_expression_evaluator_top pdee_port_assertions u_pdee_port_assertions (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

/* tb/pdee_checker.sv */
// Checker for the postfix expression evaluator: keeps its own copy of the value
// stack, predicts every drained result and compares each output transfer with it.
// Depends on pdee_pkg.
`timescale 1ns / 1ps

module pdee_checker
  import pdee_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_item_t   out_data,
  output int unsigned mismatches,
  output int unsigned awaited,
  output int unsigned results_checked,
  output int unsigned ovf_results,
  output int unsigned unf_results,
  output int unsigned dz_results
);

  logic [VAL_W-1:0] shadow_stack [STACK_DEPTH];
  int unsigned      shadow_count;
  logic             seen_ovf;
  logic             seen_unf;
  logic             seen_dz;
  out_item_t        expected_drain [$];

  function automatic void push_entry(input logic [VAL_W-1:0] v);
    if (shadow_count >= STACK_DEPTH) begin
      seen_ovf = 1'b1;
    end else begin
      shadow_stack[shadow_count] = v;
      shadow_count++;
    end
  endfunction

  function automatic logic [VAL_W-1:0] pop_entry();
    if (shadow_count == 0) begin
      seen_unf = 1'b1;
      return EMPTY_POP_VALUE;
    end
    shadow_count--;
    return shadow_stack[shadow_count];
  endfunction

  // Signed division on magnitudes; the most negative value over minus one wraps.
  function automatic logic [VAL_W-1:0] quotient_toward_zero(input logic [VAL_W-1:0] dividend,
                                                             input logic [VAL_W-1:0] divisor);
    logic [VAL_W-1:0] mag_n;
    logic [VAL_W-1:0] mag_d;
    logic [VAL_W-1:0] q;
    mag_n = dividend[VAL_W-1] ? -dividend : dividend;
    mag_d = divisor[VAL_W-1] ? -divisor : divisor;
    if (mag_d == '0) begin
      seen_dz = 1'b1;
      return '0;
    end
    q = mag_n / mag_d;
    return (dividend[VAL_W-1] ^ divisor[VAL_W-1]) ? -q : q;
  endfunction

  function automatic void evaluate_symbol(input in_item_t it);
    logic [VAL_W-1:0] rhs;
    logic [VAL_W-1:0] lhs;
    logic [VAL_W-1:0] res;
    out_item_t        r;
    if (it.symbol inside {CODE_PLUS, CODE_MINUS, CODE_STAR, CODE_SLASH}) begin
      rhs = pop_entry();
      lhs = pop_entry();
      case (it.symbol)
        CODE_PLUS:  res = lhs + rhs;
        CODE_MINUS: res = lhs - rhs;
        CODE_STAR:  res = lhs * rhs;
        default:    res = quotient_toward_zero(lhs, rhs);
      endcase
      push_entry(res);
    end else begin
      push_entry({24'd0, it.symbol} - {24'd0, CODE_ZERO});
    end

    if (it.end_of_expression) begin
      r = '0;
      r.overflow_seen  = seen_ovf;
      r.underflow_seen = seen_unf;
      r.div_zero_seen  = seen_dz;
      if (shadow_count == 0) begin
        r.last     = 1'b1;
        r.no_value = 1'b1;
        expected_drain.push_back(r);
      end else begin
        while (shadow_count > 0) begin
          shadow_count--;
          r.value = shadow_stack[shadow_count];
          r.last  = (shadow_count == 0);
          expected_drain.push_back(r);
        end
      end
      seen_ovf = 1'b0;
      seen_unf = 1'b0;
      seen_dz  = 1'b0;
    end
  endfunction

  function automatic void compare_bit(input string field, input logic want, input logic got);
    if (got !== want) begin
      $error("%s: expected %0b, got %0b", field, want, got);
      mismatches++;
    end
  endfunction

  function automatic void check_result(input out_item_t got);
    out_item_t want;
    if (expected_drain.size() == 0) begin
      $error("value: expected no result, got %0d", got.value);
      mismatches++;
      return;
    end
    want = expected_drain.pop_front();
    if (got.value !== want.value) begin
      $error("value: expected %0d, got %0d", want.value, got.value);
      mismatches++;
    end
    compare_bit("last", want.last, got.last);
    compare_bit("no_value", want.no_value, got.no_value);
    compare_bit("overflow_seen", want.overflow_seen, got.overflow_seen);
    compare_bit("underflow_seen", want.underflow_seen, got.underflow_seen);
    compare_bit("div_zero_seen", want.div_zero_seen, got.div_zero_seen);
    results_checked++;
    if (want.overflow_seen)  ovf_results++;
    if (want.underflow_seen) unf_results++;
    if (want.div_zero_seen)  dz_results++;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      shadow_count = 0;
      seen_ovf     = 1'b0;
      seen_unf     = 1'b0;
      seen_dz      = 1'b0;
      expected_drain.delete();
    end else begin
      if (out_valid && out_ready) check_result(out_data);
      if (in_valid && in_ready) evaluate_symbol(in_data);
    end
    awaited = expected_drain.size();
  end

endmodule

/* tb/postfix_digit_expression_evaluator_top_tb.sv */
// Testbench top for the postfix expression evaluator: clock, reset, stimulus
// and verdict. Depends on pdee_pkg, pdee_checker and the evaluator RTL.
`timescale 1ns / 1ps

module postfix_digit_expression_evaluator_top_tb;
  import pdee_pkg::*;

  localparam int HALF_PERIOD_NS  = 10;
  localparam int RESET_CYCLES    = 6;
  localparam int RUN_LIMIT_NS    = 10_000_000;
  localparam int RANDOM_SYMBOLS  = 60;
  localparam int IDLE_PERCENT    = 14;
  localparam int RX_HOLD_CYCLES  = 400;
  localparam int SETTLE_CYCLES   = 100;

  localparam logic [7:0] OPERATORS [4] = '{CODE_PLUS, CODE_MINUS, CODE_STAR, CODE_SLASH};

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  int unsigned mismatches;
  int unsigned awaited;
  int unsigned results_checked;
  int unsigned ovf_results;
  int unsigned unf_results;
  int unsigned dz_results;

  // Stimulus-side bookkeeping and the switches shared with the receiver.
  int unsigned symbols_sent     = 0;
  int unsigned expressions_sent = 0;
  bit          tx_steady        = 1'b0;
  bit          rx_steady        = 1'b0;
  int unsigned hold_ticket      = 0;

  always #(HALF_PERIOD_NS) clk = ~clk;

  postfix_digit_expression_evaluator_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  pdee_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .mismatches      (mismatches),
    .awaited         (awaited),
    .results_checked (results_checked),
    .ovf_results     (ovf_results),
    .unf_results     (unf_results),
    .dz_results      (dz_results)
  );

  // Receiver: drop ready at random, hold it high through the steady stretch,
  // and hold it low for a long, self-counted stretch whenever a new hold is
  // requested, so that the drain backs up into the input channel.
  int unsigned hold_served = 0;
  int unsigned hold_left   = 0;

  always @(negedge clk) begin
    if (hold_ticket != hold_served) begin
      hold_served = hold_ticket;
      hold_left   = RX_HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (rx_steady) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
    end
  end

  // Offer one symbol and hold it until the transfer happens. Valid is only
  // ever assigned once per falling edge; a following call keeps it high unless it first idles.
  task automatic send_symbol(input logic [7:0] sym, input logic eoe);
    in_item_t item;
    item.symbol            = sym;
    item.end_of_expression = eoe;
    while (!tx_steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    symbols_sent++;
    if (eoe) expressions_sent++;
  endtask

  // Drop valid and wait until every predicted result has been taken.
  task automatic pause_until_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (awaited != 0);
  endtask

  // Well-formed postfix with random content: operators only when two values
  // are stacked, ending once the operands are used up and at most 'keep'
  // values remain, so the drain can return several results.
  task automatic send_expression(input int n_opnd, input bit wild, input int keep);
    int         stacked;
    int         left;
    logic [7:0] sym;
    stacked = 0;
    left    = n_opnd;
    while (left > 0 || stacked > keep) begin
      if (stacked >= 2 && (left == 0 || $urandom_range(0, 2) == 0)) begin
        sym = OPERATORS[$urandom_range(0, 3)];
        stacked--;
      end else begin
        if (wild) begin
          // any non-operator code, so the pushed value spans -48..207
          do sym = 8'($urandom_range(0, 255)); while (sym inside {OPERATORS});
        end else begin
          sym = CODE_ZERO + 8'($urandom_range(0, 9));
        end
        stacked++;
        left--;
      end
      send_symbol(sym, left == 0 && stacked <= keep);
    end
  endtask

  // Noise: arbitrary codes with operators mixed in, so pops of an empty stack
  // and half-built expressions show up; always closed by an end marker.
  task automatic send_noise(input int n);
    logic [7:0] sym;
    for (int k = 0; k < n; k++) begin
      sym = ($urandom_range(0, 3) == 0) ? OPERATORS[$urandom_range(0, 3)]
                                        : 8'($urandom_range(0, 255));
      send_symbol(sym, k == n - 1);
    end
  endtask

  initial begin
    int unsigned random_start;
    int unsigned progress;
    int          choice;

    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: every operator, the lowest and highest codes, pops of an
    // empty stack (-1 / -1) and a division by zero, then the most negative
    // value divided by minus one, then a drain of two values.
    send_symbol(CODE_SLASH, 1'b0);
    send_symbol(8'h00, 1'b0);
    send_symbol(CODE_MINUS, 1'b0);
    send_symbol(8'hFF, 1'b0);
    send_symbol(CODE_STAR, 1'b0);
    send_symbol(CODE_ZERO, 1'b0);
    send_symbol(CODE_SLASH, 1'b1);

    // 128^4 * 8 wraps to the most negative value
    send_symbol(CODE_ZERO + 8'd128, 1'b0);
    send_symbol(CODE_ZERO + 8'd128, 1'b0);
    send_symbol(CODE_STAR, 1'b0);
    send_symbol(CODE_ZERO + 8'd128, 1'b0);
    send_symbol(CODE_STAR, 1'b0);
    send_symbol(CODE_ZERO + 8'd128, 1'b0);
    send_symbol(CODE_STAR, 1'b0);
    send_symbol(CODE_ZERO + 8'd8, 1'b0);
    send_symbol(CODE_STAR, 1'b0);
    send_symbol(CODE_ZERO, 1'b0);
    send_symbol(CODE_ZERO + 8'd1, 1'b0);
    send_symbol(CODE_MINUS, 1'b0);
    send_symbol(CODE_SLASH, 1'b1);

    send_symbol(CODE_ZERO + 8'd7, 1'b0);
    send_symbol(CODE_ZERO + 8'd9, 1'b0);
    send_symbol(CODE_ZERO + 8'd5, 1'b0);
    send_symbol(CODE_PLUS, 1'b1);

    // Sender pause: nothing offered until every result is back.
    pause_until_drained();

    // Back-pressure: hold the receiver off while a full stack plus one more
    // push, then a deeper mixed expression, are offered. The first drain
    // stalls at the output and the input stops accepting transfers.
    hold_ticket++;
    for (int k = 0; k <= STACK_DEPTH; k++) begin
      send_symbol(CODE_ZERO + 8'($urandom_range(0, 9)), k == STACK_DEPTH);
    end
    send_expression(STACK_DEPTH + 3, 1'b1, STACK_DEPTH);
    pause_until_drained();

    // Random: mostly short well-formed expressions, a few deep ones that can
    // overflow the stack, and some noise. Idle on neither side for a while
    // in the middle.
    random_start = symbols_sent;
    progress     = 0;
    while (progress < RANDOM_SYMBOLS) begin
      tx_steady = (progress >= 15 && progress < 45);
      rx_steady = tx_steady;
      choice    = $urandom_range(0, 99);
      if (choice < 72) begin
        send_expression($urandom_range(1, 6), $urandom_range(0, 3) == 0, $urandom_range(1, 3));
      end else if (choice < 80) begin
        send_expression($urandom_range(14, 19), 1'b1, $urandom_range(1, STACK_DEPTH));
      end else begin
        send_noise($urandom_range(1, 8));
      end
      progress = symbols_sent - random_start;
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;

    // Wind down: wait for the last drain, then let a stray result show up.
    pause_until_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("covered %0d symbols in %0d expressions, %0d drained results checked",
             symbols_sent, expressions_sent, results_checked);
    $display("results carrying overflow / underflow / divide-by-zero flags: %0d / %0d / %0d",
             ovf_results, unf_results, dz_results);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog: a hung handshake or a missing result ends the run here.
  initial begin
    #(RUN_LIMIT_NS);
    $display("timed out with %0d results still awaited", awaited);
    $display("status: fail");
    $finish;
  end

endmodule
